/* design/nco_pkg.sv */
// shared types, register indexes and constants of the tone and chirp generator
// also holds the elaboration-time sine table entry function used by the rom
package nco_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int PHASE_BITS     = 32;
   localparam int STEP_FRAC_BITS = 16;
   localparam int STEP_BITS      = PHASE_BITS + STEP_FRAC_BITS;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC_BITS = 15;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET       = 16'h8000;
   localparam logic [31:0]          RUN_LENGTH_RESET = 32'd1;

   // pi/2 in q30
   localparam logic [63:0] PI_HALF_Q30 = 64'h0000_0000_6487_ED51;

   // taylor terms stay below 2^34, so a 43-bit reciprocal gives the exact quotient
   localparam int RECIP_SHIFT = 43;

   // ceil(2^RECIP_SHIFT / d) for the taylor divisors d = 2n(2n+1), n = 1..10
   localparam logic [63:0] TAYLOR_RECIP [10] = '{
      ((64'd1 << RECIP_SHIFT) + 64'd5)   / 64'd6,
      ((64'd1 << RECIP_SHIFT) + 64'd19)  / 64'd20,
      ((64'd1 << RECIP_SHIFT) + 64'd41)  / 64'd42,
      ((64'd1 << RECIP_SHIFT) + 64'd71)  / 64'd72,
      ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110,
      ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156,
      ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210,
      ((64'd1 << RECIP_SHIFT) + 64'd271) / 64'd272,
      ((64'd1 << RECIP_SHIFT) + 64'd341) / 64'd342,
      ((64'd1 << RECIP_SHIFT) + 64'd419) / 64'd420
   };

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE_SWEEP = 3'd0,
      CSR_START_STEP = 3'd1,
      CSR_CHIRP_STEP = 3'd2,
      CSR_GAIN       = 3'd3,
      CSR_RUN_LENGTH = 3'd4
   } csr_index_type;

   // per-sample side information that rides along the pipeline
   typedef struct packed {
      logic neg;        // lower half of the turn, negate the magnitude
      logic force_amp;  // mirrored index zero, peak of the sine
      logic last;       // final sample of the run
   } ctrl_type;

   // quarter-wave sine entry k, q30 taylor series with truncated products
   function automatic logic [63:0] sine_entry(input int unsigned k,
                                              input int unsigned addr_bits,
                                              input logic [63:0] amp);
      logic [63:0]  x;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  v;
      logic [127:0] quot;
      x    = (PI_HALF_Q30 * 64'(k)) >> addr_bits;
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         quot = 128'(term) * 128'(TAYLOR_RECIP[4'(n - 1)]);
         term = 64'(quot >> RECIP_SHIFT);
         if ((n & 1) != 0) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      v = (sum * amp + (64'd1 << 29)) >> 30;
      if (v > amp) begin
         v = amp;
      end
      return v;
   endfunction

endpackage

/* design/nco_sine_rom.sv */
// quarter-wave sine rom with registered read
// contents built at elaboration from nco_pkg::sine_entry
module nco_sine_rom #(
   parameter int ADDR_BITS   = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [ADDR_BITS-1:0]   addr,
   output logic [SAMPLE_BITS-2:0] data
);
   import nco_pkg::*;

   localparam int DEPTH    = 1 << ADDR_BITS;
   localparam int MAG_BITS = SAMPLE_BITS - 1;
   localparam logic [63:0] AMP = (64'd1 << MAG_BITS) - 64'd1;

   typedef logic [MAG_BITS-1:0] rom_table_type [DEPTH];

   function automatic rom_table_type build_table();
      rom_table_type t;
      for (int k = 0; k < DEPTH; k++) begin
         t[k] = MAG_BITS'(sine_entry(k, ADDR_BITS, AMP));
      end
      return t;
   endfunction

   localparam rom_table_type SINE_TABLE = build_table();

   logic [MAG_BITS-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= SINE_TABLE[addr];
      end
   end

   assign data = data_ff;

endmodule

/* design/nco_phase_gen.sv */
// configuration registers, phase and increment accumulators, run counter
// forms the rom address and side flags of each sample; uses nco_pkg
module nco_phase_gen #(
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [nco_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nco_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               accept,
   input  logic                               restart,
   output logic [TABLE_ADDR_BITS-1:0]         rom_addr,
   output nco_pkg::ctrl_type                  ctrl,
   output logic [nco_pkg::GAIN_BITS-1:0]      gain
);
   import nco_pkg::*;

   logic                  mode_ff;
   logic [PHASE_BITS-1:0] start_ff;
   logic [31:0]           chirp_ff;
   logic [GAIN_BITS-1:0]  gain_ff;
   logic [31:0]           run_length_ff;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [31:0]           index_ff, index_in;

   logic [PHASE_BITS-1:0]      phase_base, sweep_phase, look_phase;
   logic [STEP_BITS-1:0]       step_base, step_reload, chirp_ext;
   logic [31:0]                index_base;
   logic [32:0]                index_inc;
   logic                       last;
   logic [1:0]                 quad;
   logic [TABLE_ADDR_BITS-1:0] tidx, tidx_mirror;

   assign step_reload = {start_ff, STEP_FRAC_BITS'(0)};
   assign chirp_ext   = {{(STEP_BITS-32){chirp_ff[31]}}, chirp_ff};

   always_comb begin
      phase_base  = restart ? '0 : phase_ff;
      step_base   = restart ? step_reload : step_ff;
      index_base  = restart ? '0 : index_ff;
      sweep_phase = phase_base + step_base[STEP_BITS-1:STEP_FRAC_BITS];
      look_phase  = mode_ff ? sweep_phase : phase_base;
      index_inc   = {1'b0, index_base} + 33'd1;
      // a run length of zero behaves like one
      last        = index_inc >= {1'b0, run_length_ff};
      if (last) begin
         phase_in = '0;
         step_in  = step_reload;
         index_in = '0;
      end else begin
         phase_in = mode_ff ? sweep_phase : phase_base + start_ff;
         step_in  = mode_ff ? step_base + chirp_ext : step_base;
         index_in = index_inc[31:0];
      end
   end

   always_comb begin
      quad           = look_phase[PHASE_BITS-1 -: 2];
      tidx           = look_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
      tidx_mirror    = '0 - tidx;
      rom_addr       = quad[0] ? tidx_mirror : tidx;
      ctrl.neg       = quad[1];
      ctrl.force_amp = quad[0] && (tidx == '0);
      ctrl.last      = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         start_ff      <= '0;
         chirp_ff      <= '0;
         gain_ff       <= GAIN_RESET;
         run_length_ff <= RUN_LENGTH_RESET;
         phase_ff      <= '0;
         step_ff       <= '0;
         index_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE_SWEEP: mode_ff <= csr_wdata[0];
            CSR_START_STEP: begin
               start_ff <= csr_wdata;
               step_ff  <= {csr_wdata, STEP_FRAC_BITS'(0)};
            end
            CSR_CHIRP_STEP: chirp_ff      <= csr_wdata;
            CSR_GAIN:       gain_ff       <= csr_wdata[GAIN_BITS-1:0];
            CSR_RUN_LENGTH: run_length_ff <= csr_wdata;
            default: ;
         endcase
      end else if (accept) begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         index_ff <= index_in;
      end
   end

   assign gain = gain_ff;

endmodule

/* design/nco_scale.sv */
// gain multiply, rounding, saturation and sign restore, two registered stages
// ends in the result register; uses nco_pkg
module nco_scale #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [SAMPLE_BITS-2:0]        in_mag,
   input  nco_pkg::ctrl_type             in_ctrl,
   input  logic [nco_pkg::GAIN_BITS-1:0] gain,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [SAMPLE_BITS-1:0]        out_sample,
   output logic                          out_last
);
   import nco_pkg::*;

   localparam int MAG_BITS  = SAMPLE_BITS - 1;
   localparam int PROD_BITS = MAG_BITS + GAIN_BITS;
   localparam int RND_BITS  = PROD_BITS + 1 - GAIN_FRAC_BITS;
   localparam logic [MAG_BITS-1:0]  AMP        = '1;
   localparam logic [PROD_BITS:0]   ROUND_HALF = (PROD_BITS+1)'(1) << (GAIN_FRAC_BITS - 1);

   logic                   prod_valid_ff, prod_valid_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   ctrl_type               prod_ctrl_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   last_ff;

   logic                   out_free, prod_free;
   logic [MAG_BITS-1:0]    mag;
   logic [PROD_BITS:0]     rounded;
   logic [RND_BITS-1:0]    rounded_q;
   logic [MAG_BITS-1:0]    sat;
   logic [SAMPLE_BITS-1:0] sat_ext;

   assign out_free  = !out_valid_ff || out_ready;
   assign prod_free = !prod_valid_ff || out_free;
   assign in_ready  = prod_free;

   always_comb begin
      mag     = in_ctrl.force_amp ? AMP : in_mag;
      prod_in = PROD_BITS'(mag) * PROD_BITS'(gain);
   end

   // round half away from zero on the magnitude, then clip to full scale
   always_comb begin
      rounded   = {1'b0, prod_ff} + ROUND_HALF;
      rounded_q = rounded[PROD_BITS:GAIN_FRAC_BITS];
      sat       = (rounded_q > RND_BITS'(AMP)) ? AMP : rounded_q[MAG_BITS-1:0];
      sat_ext   = {1'b0, sat};
      sample_in = prod_ctrl_ff.neg ? ('0 - sat_ext) : sat_ext;
   end

   always_comb begin
      prod_valid_in = prod_free ? in_valid : prod_valid_ff;
      out_valid_in  = out_free ? prod_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_free && in_valid) begin
         prod_ff      <= prod_in;
         prod_ctrl_ff <= in_ctrl;
      end
      if (out_free && prod_valid_ff) begin
         sample_ff <= sample_in;
         last_ff   <= prod_ctrl_ff.last;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_sample = sample_ff;
   assign out_last   = last_ff;

endmodule

/* design/nco_tone_and_chirp_generator_core.sv */
// top level of the tone and chirp generator
// instantiates nco_phase_gen, nco_sine_rom and nco_scale; uses nco_pkg
//
// One request transfer yields one signed sine sample on the response side, and
// a new request is taken every clock while the response side does not stall,
// so the block then delivers one sample per cycle. The request flag restart
// clears phase and run counter and reloads the increment with start_step
// before that sample. Mode 0 outputs the tone at phase start_step*i from 0;
// mode 1 first advances the phase by the current increment and changes the
// increment by the signed chirp_step (2^-16 units) per sample. Each run holds
// run_length samples, the last one flagged by rsp_tlast, and then restarts.
// The request edge updates the accumulators and loads the registered rom
// read, the gain product register follows, then rounding and saturation
// load the result register. Stalls on the response side back up stage by
// stage, and empty stages keep taking requests. Registers are to be written
// by the user only while idle; the block does not enforce it.
module nco_tone_and_chirp_generator_core #(
   parameter int TABLE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [nco_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nco_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [0] restart
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]   rsp_tdata,  // [SAMPLE_BITS-1:0] sample
   output logic                               rsp_tlast   // last
);
   import nco_pkg::*;

   localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   logic                       accept;
   logic                       rom_valid_ff, rom_valid_in;
   ctrl_type                   rom_ctrl_ff;
   ctrl_type                   ctrl;
   logic [TABLE_ADDR_BITS-1:0] rom_addr;
   logic [SAMPLE_BITS-2:0]     rom_data;
   logic [GAIN_BITS-1:0]       gain;
   logic                       scale_ready;
   logic                       rom_free;
   logic [SAMPLE_BITS-1:0]     sample;

   assign rom_free   = !rom_valid_ff || scale_ready;
   assign req_tready = rom_free;
   assign accept     = req_tvalid && rom_free;

   nco_phase_gen #(
      .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
   ) u_phase (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .accept   (accept),
      .restart  (req_tdata[0]),
      .rom_addr (rom_addr),
      .ctrl     (ctrl),
      .gain     (gain)
   );

   nco_sine_rom #(
      .ADDR_BITS  (TABLE_ADDR_BITS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_rom (
      .clock(clock),
      .en   (accept),
      .addr (rom_addr),
      .data (rom_data)
   );

   assign rom_valid_in = rom_free ? req_tvalid : rom_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_valid_ff <= 1'b0;
      end else begin
         rom_valid_ff <= rom_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rom_ctrl_ff <= ctrl;
      end
   end

   nco_scale #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rom_valid_ff),
      .in_ready  (scale_ready),
      .in_mag    (rom_data),
      .in_ctrl   (rom_ctrl_ff),
      .gain      (gain),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_sample(sample),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = TDATA_BITS'(sample);

endmodule

/* design/nco_checker.sv */
// port-level checks of the tone and chirp generator over time
// bound to nco_tone_and_chirp_generator_core below
module nco_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   localparam logic [SAMPLE_BITS-1:0] NEG_FULL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // when the result side drains, every stage can move and requests are taken
   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request side blocked while result side drains");

   // saturation is symmetric, the most negative code never shows
   a_sat_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[SAMPLE_BITS-1:0] != NEG_FULL)
      else $error("sample outside symmetric range");

   // a valid result carries a fully known payload
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown({rsp_tdata, rsp_tlast}))
      else $error("response payload unknown");

endmodule

bind nco_tone_and_chirp_generator_core nco_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_nco_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);

/* tb/nco_tone_and_chirp_generator_core_tb.sv */
// self-checking testbench for the tone and chirp generator core
// predicts every sample from its own sine table and accumulators; uses nco_pkg
`timescale 1ns / 100ps

module nco_tone_and_chirp_generator_core_tb;
   import nco_pkg::*;

   localparam int ADDR_BITS    = 10;
   localparam int SMP_BITS     = 16;
   localparam int ROM_DEPTH    = 1 << ADDR_BITS;
   localparam int PIPE_DEPTH   = 3;
   localparam int RANDOM_ITEMS = 700;
   localparam int CALM_TAIL    = 120;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [SMP_BITS-1:0] PEAK = SMP_BITS'((1 << (SMP_BITS - 1)) - 1);

   typedef struct {
      logic [SMP_BITS-1:0] sample;
      logic                last;
   } tone_sample_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [((SMP_BITS+7)/8)*8-1:0] rsp_tdata;  // [SMP_BITS-1:0] sample
   logic        rsp_tlast;  // last

   // generator state as the block should hold it
   logic [SMP_BITS-1:0] sine_rom [ROM_DEPTH];
   logic        sweep_on;
   logic [31:0] start_inc;
   logic [31:0] chirp_inc;
   logic [15:0] gain_q15;
   logic [31:0] run_len;
   logic [31:0] phase;
   logic [47:0] inc_acc;
   logic [31:0] sample_no;

   tone_sample_type expected_samples[$];
   tone_sample_type sample_want;
   int  err_count     = 0;
   int  n_checked     = 0;
   int  n_lasts       = 0;
   int  n_settings    = 0;
   int  cycle_count   = 0;
   int  rsp_stall_left = 0;
   bit  idling_on     = 1'b1;

   nco_tone_and_chirp_generator_core #(
      .TABLE_ADDR_BITS(ADDR_BITS),
      .SAMPLE_BITS    (SMP_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #6 clock = ~clock;

   // quarter-wave entry: q30 taylor series of sin, products truncated
   function automatic logic [SMP_BITS-1:0] quarter_sine(input int k);
      longint unsigned x;
      longint unsigned term;
      longint unsigned acc;
      longint unsigned r;
      x    = (PI_HALF_Q30 * 64'(k)) >> ADDR_BITS;
      term = x;
      acc  = x;
      for (int n = 1; n <= 10; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / (64'(2 * n) * 64'(2 * n + 1));
         if (n % 2 == 1) begin
            acc = (acc >= term) ? acc - term : 64'd0;
         end else begin
            acc = acc + term;
         end
      end
      r = (acc * 64'(PEAK) + (64'd1 << 29)) >> 30;
      if (r > 64'(PEAK)) begin
         r = 64'(PEAK);
      end
      return r[SMP_BITS-1:0];
   endfunction

   // table lookup with quadrant folding, then gain with rounding and saturation
   function automatic logic [SMP_BITS-1:0] scaled_sine(input logic [31:0] ph);
      logic [1:0]           quad;
      logic [ADDR_BITS-1:0] idx;
      logic [ADDR_BITS-1:0] mirror;
      logic [SMP_BITS-1:0]  mag;
      longint unsigned      prod;
      logic [SMP_BITS-1:0]  res;
      quad   = ph[31:30];
      idx    = ph[29 -: ADDR_BITS];
      mirror = -idx;
      if (quad[0]) begin
         mag = (idx == 0) ? PEAK : sine_rom[mirror];
      end else begin
         mag = sine_rom[idx];
      end
      prod = (64'(mag) * 64'(gain_q15) + 64'd16384) >> GAIN_FRAC_BITS;
      if (prod > 64'(PEAK)) begin
         prod = 64'(PEAK);
      end
      res = prod[SMP_BITS-1:0];
      if (quad[1]) begin
         res = -res;
      end
      return res;
   endfunction

   function automatic void begin_run();
      phase     = '0;
      sample_no = '0;
      inc_acc   = {start_inc, 16'h0000};
   endfunction

   function automatic void predict_tick(input logic restart);
      tone_sample_type s;
      if (restart) begin
         begin_run();
      end
      if (sweep_on) begin
         phase    = phase + inc_acc[47:16];
         s.sample = scaled_sine(phase);
         inc_acc  = inc_acc + {{16{chirp_inc[31]}}, chirp_inc};
      end else begin
         s.sample = scaled_sine(phase);
         phase    = phase + start_inc;
      end
      // run length zero behaves like one
      s.last = (33'(sample_no) + 33'd1) >= 33'(run_len);
      expected_samples.push_back(s);
      if (s.last) begin
         begin_run();
      end else begin
         sample_no = sample_no + 32'd1;
      end
   endfunction

   // called just after a falling edge, returns just after a falling edge
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MODE_SWEEP: sweep_on = val[0];
         CSR_START_STEP: begin
            start_inc = val;
            inc_acc   = {val, 16'h0000};
         end
         CSR_CHIRP_STEP: chirp_inc = val;
         CSR_GAIN:       gain_q15  = val[15:0];
         CSR_RUN_LENGTH: run_len   = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // valid stays high on return so back-to-back transfers need no gap
   task automatic send_tick(input logic restart);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tick(restart);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   task automatic test_reset_state();
      // tone at step zero with run length one: silent, every sample closes a run
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_idle();
   endtask

   task automatic test_tone_extremes();
      // quarter-turn steps with run length zero: every sample closes a run at phase zero
      write_reg(CSR_RUN_LENGTH, 32'd0);
      write_reg(CSR_START_STEP, 32'h4000_0000);
      write_reg(CSR_GAIN, 32'h0000_FFFF);
      n_settings++;
      repeat (5) send_tick(1'b0);
      wait_idle();
      write_reg(CSR_GAIN, 32'd0);
      write_reg(CSR_START_STEP, 32'hFFFF_FFFF);
      write_reg(CSR_RUN_LENGTH, 32'd3);
      n_settings++;
      repeat (3) send_tick(1'b0);
      wait_idle();
      write_reg(CSR_GAIN, 32'h0000_8000);
      write_reg(CSR_START_STEP, 32'h0123_4567);
      write_reg(CSR_RUN_LENGTH, 32'hFFFF_FFFF);
      n_settings++;
      repeat (3) send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_idle();
   endtask

   task automatic test_sweep_extremes();
      // increment accumulator wraps with the largest chirp in both directions
      write_reg(CSR_MODE_SWEEP, 32'd1);
      write_reg(CSR_START_STEP, 32'hFFFF_FFFF);
      write_reg(CSR_CHIRP_STEP, 32'h7FFF_FFFF);
      write_reg(CSR_RUN_LENGTH, 32'd4);
      n_settings++;
      repeat (4) send_tick(1'b0);
      wait_idle();
      write_reg(CSR_CHIRP_STEP, 32'h8000_0000);
      write_reg(CSR_START_STEP, 32'd0);
      n_settings++;
      repeat (3) send_tick(1'b0);
      wait_idle();
   endtask

   task automatic test_unused_indexes();
      for (int i = int'(CSR_RUN_LENGTH) + 1; i < (1 << CSR_INDEX_BITS); i++) begin
         write_reg(CSR_INDEX_BITS'(i), $urandom);
      end
      repeat (2) send_tick(1'b0);
      wait_idle();
   endtask

   task automatic test_random_runs();
      int          sent;
      int          burst;
      int          pick;
      logic [31:0] val;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         if ($urandom_range(0, 2) != 0) begin
            write_reg(CSR_MODE_SWEEP, 32'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 5);
            case (pick)
               0: val = 32'd0;
               1: val = 32'hFFFF_FFFF;
               2, 3: val = $urandom_range(0, 1 << 24);
               default: val = $urandom;
            endcase
            write_reg(CSR_START_STEP, val);
         end
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 6);
            case (pick)
               0: val = 32'h7FFF_FFFF;
               1: val = 32'h8000_0000;
               2: val = 32'd0;
               3, 4: val = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
               default: val = $urandom;
            endcase
            write_reg(CSR_CHIRP_STEP, val);
         end
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 5);
            case (pick)
               0: val = 32'd0;
               1: val = 32'h0000_8000;
               2: val = 32'h0000_FFFF;
               default: val = $urandom_range(0, 32768);
            endcase
            write_reg(CSR_GAIN, val);
         end
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 7);
            case (pick)
               0: val = 32'd0;
               1: val = 32'd1;
               2: val = 32'hFFFF_FFFF;
               default: val = $urandom_range(1, 24);
            endcase
            write_reg(CSR_RUN_LENGTH, val);
         end
         n_settings++;
         // quiet stretches now and then, none near the end
         idling_on = (RANDOM_ITEMS - sent > CALM_TAIL) && ($urandom_range(0, 4) != 0);
         burst = $urandom_range(10, 60);
         repeat (burst) send_tick($urandom_range(0, 15) == 0);
         sent += burst;
      end
      idling_on = 1'b0;
   endtask

   // response side backpressure in random bursts
   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(1, 11);
      end
      rsp_tready <= (rsp_stall_left == 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $error("sample transfer with nothing expected: sample %0d last %0b",
                   $signed(rsp_tdata[SMP_BITS-1:0]), rsp_tlast);
            err_count++;
         end else begin
            sample_want = expected_samples.pop_front();
            if (rsp_tdata[SMP_BITS-1:0] !== sample_want.sample) begin
               $error("sample mismatch: expected %0d, actual %0d",
                      $signed(sample_want.sample), $signed(rsp_tdata[SMP_BITS-1:0]));
               err_count++;
            end
            if (rsp_tlast !== sample_want.last) begin
               $error("last mismatch: expected %0b, actual %0b", sample_want.last, rsp_tlast);
               err_count++;
            end
            n_checked++;
            if (sample_want.last) begin
               n_lasts++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d samples still expected",
               cycle_count, expected_samples.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin
      for (int k = 0; k < ROM_DEPTH; k++) begin
         sine_rom[k] = quarter_sine(k);
      end
      sweep_on  = 1'b0;
      start_inc = '0;
      chirp_inc = '0;
      gain_q15  = GAIN_RESET;
      run_len   = RUN_LENGTH_RESET;
      begin_run();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_tone_extremes();
      test_sweep_extremes();
      test_unused_indexes();
      test_random_runs();

      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (4 * PIPE_DEPTH) @(posedge clock);

      $display("checked %0d samples (%0d run ends) across %0d register settings",
               n_checked, n_lasts, n_settings);
      $display("covered tone and sweep modes, restarts, gain saturation and step wrap");
      if (err_count == 0 && expected_samples.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
design/nco_pkg.sv
design/nco_sine_rom.sv
design/nco_phase_gen.sv
design/nco_scale.sv
design/nco_tone_and_chirp_generator_core.sv
design/nco_checker.sv
tb/nco_tone_and_chirp_generator_core_tb.sv
